// ===== hdl/lkvc_pkg.sv =====
// Shared types and codes for the LRU key-value cache.
package lkvc_pkg;

  // Request operation codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // Width of the capacity register.
  localparam int CAP_W = 5;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// A get result strobes on done, registered from the decide step that follows the scan
// pass over the entries in use; on an empty cache the scan pass is skipped.
// A new request is taken only in idle: a get miss returns there from the decide step,
// a get hit or a set from the rank rewrite pass after it (skipped on an empty cache).
// Reset (rst, synchronous): empties the cache, capacity 16; the receiver cannot stall.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_data,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [KEY_WIDTH-1:0]  lookup_key,
  input  logic [DATA_WIDTH-1:0] write_data,
  // result side
  output logic                  done,
  output logic                  hit,
  output logic [DATA_WIDTH-1:0] read_data
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int KD_W   = KEY_WIDTH + DATA_WIDTH;

  // Entry storage: key and value share one word per slot; the recency rank
  // lives in a second memory so it can be rewritten on its own.
  // Slots 0..fill-1 are the valid ones, since slots fill in order and are
  // never freed; that replaces a per-entry valid bit.
  logic [KD_W-1:0]       kd_mem   [MAX_ENTRIES];
  logic [IDX_W-1:0]      rank_mem [MAX_ENTRIES];

  state_t state;

  logic [CAP_W-1:0]      cap;
  logic [FILL_W-1:0]     fill;

  // Latched request
  logic                  cmd_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic [FILL_W-1:0]     scan_n;    // entries in use when the request arrived

  // Pass control: cnt issues reads, pidx/pv tag the data coming back.
  logic [FILL_W-1:0]     cnt;
  logic [IDX_W-1:0]      pidx;
  logic                  pv;

  // Memory read port
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [KD_W-1:0]       kd_rd;
  logic [KEY_WIDTH-1:0]  key_rd;
  logic [DATA_WIDTH-1:0] data_rd;
  logic [IDX_W-1:0]      rank_rd;

  // Scan results
  logic                  found;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      match_rank;
  logic [DATA_WIDTH-1:0] match_data;
  logic [IDX_W-1:0]      old_idx;
  logic [IDX_W-1:0]      old_rank;

  // Rank rewrite controls for the update pass
  logic [IDX_W-1:0]      tgt;
  logic [IDX_W-1:0]      touch_rank;
  logic                  age_all;

  // Write ports
  logic                  kd_we;
  logic [IDX_W-1:0]      kd_waddr;
  logic                  rank_we;
  logic [IDX_W-1:0]      rank_waddr;
  logic [IDX_W-1:0]      rank_wdata;

  // Decision made once the scan is over
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      eff_cap;
  logic                  evict;
  logic [IDX_W-1:0]      dec_tgt;
  logic [IDX_W-1:0]      dec_rank;
  logic                  dec_age_all;
  logic                  dec_update;

  logic                  accept;
  logic                  last_back;
  logic [IDX_W-1:0]      new_rank;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign last_back = pv && (FILL_W'(pidx) == (scan_n - 1'b1));

  assign key_rd  = kd_rd[KD_W-1:DATA_WIDTH];
  assign data_rd = kd_rd[DATA_WIDTH-1:0];

  // Clamp capacity into 1..MAX_ENTRIES.
  always_comb begin
    cap_ext = CMP_W'(cap);
    if (cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = (CMP_W'(fill) >= eff_cap) && (fill != '0);

  // Pick the slot to promote and how the other ranks move.
  always_comb begin
    if (found) begin
      dec_tgt     = match_idx;
      dec_rank    = match_rank;
      dec_age_all = 1'b0;
    end else if (evict) begin
      dec_tgt     = old_idx;
      dec_rank    = old_rank;
      dec_age_all = 1'b0;
    end else begin
      // Fresh slot lies past every valid one: age them all.
      dec_tgt     = fill[IDX_W-1:0];
      dec_rank    = '0;
      dec_age_all = 1'b1;
    end
    dec_update = found || (cmd_q == CMD_SET);
  end

  // Rank of the entry coming back during the update pass.
  always_comb begin
    if ((pidx == tgt) && !age_all) begin
      new_rank = '0;
    end else if (age_all || (rank_rd < touch_rank)) begin
      new_rank = rank_rd + 1'b1;
    end else begin
      new_rank = rank_rd;
    end
  end

  // Read issue: one entry per cycle while the pass still has entries left.
  assign rd_en   = ((state == ST_SCAN) || (state == ST_UPDATE)) && (cnt < scan_n);
  assign rd_addr = cnt[IDX_W-1:0];

  // Write port selection. On a set that hits, the stored key equals key_q,
  // so key and value are written together in every set.
  always_comb begin
    kd_we      = 1'b0;
    kd_waddr   = dec_tgt;
    rank_we    = 1'b0;
    rank_waddr = pidx;
    rank_wdata = new_rank;
    if ((state == ST_DECIDE) && (cmd_q == CMD_SET)) begin
      kd_we = 1'b1;
      if (!found && !evict) begin
        // New slot starts as the most recent one.
        rank_we    = 1'b1;
        rank_waddr = dec_tgt;
        rank_wdata = '0;
      end
    end else if ((state == ST_UPDATE) && pv) begin
      rank_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      kd_rd   <= kd_mem[rd_addr];
      rank_rd <= rank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (kd_we) begin
      kd_mem[kd_waddr] <= {key_q, wdata_q};
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_W'(16);
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
      pv    <= 1'b0;
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      // Strobe the result in the cycle after the decision step of a get.
      done <= (state == ST_DECIDE) && (cmd_q == CMD_GET);
      pv   <= rd_en;
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            found <= 1'b0;
            if (fill == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Compare each returning key; track the oldest valid entry.
          if (pv && (key_rd == key_q) && !found) begin
            found <= 1'b1;
          end
          if (last_back) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if ((cmd_q == CMD_SET) && !found && !evict) begin
            fill <= fill + 1'b1;
          end
          cnt <= '0;
          if (dec_update && (scan_n != '0)) begin
            state <= ST_UPDATE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_UPDATE: begin
          if (last_back) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      key_q   <= lookup_key;
      wdata_q <= write_data;
      scan_n  <= fill;
    end
    if (rd_en) begin
      pidx <= rd_addr;
    end
    if ((state == ST_SCAN) && pv) begin
      if ((key_rd == key_q) && !found) begin
        match_idx  <= pidx;
        match_rank <= rank_rd;
        match_data <= data_rd;
      end
      if ((pidx == '0) || (rank_rd > old_rank)) begin
        old_idx  <= pidx;
        old_rank <= rank_rd;
      end
    end
    if (state == ST_DECIDE) begin
      tgt        <= dec_tgt;
      touch_rank <= dec_rank;
      age_all    <= dec_age_all;
      hit        <= found;
      read_data  <= found ? match_data : '0;
    end
  end

  // A result only follows the decision step of a get.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DECIDE) && ($past(cmd_q) == CMD_GET))
    else $error("result strobe without a get decision");

  // Entry count stays within the storage.
  assert property (@(posedge clk) disable iff (rst)
    CMP_W'(fill) <= CMP_W'(MAX_ENTRIES))
    else $error("fill count beyond storage depth");

  // A get never changes the entry count.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && (cmd_q == CMD_GET) |=> fill == $past(fill))
    else $error("get request changed the fill count");

endmodule
